FILE: hdl/mdpb_pkg.sv
// ----------------------------------------------------------------------------
// mdpb_pkg
// Shared types, constants and helpers of the min-depth pyramid builder.
// ----------------------------------------------------------------------------
package mdpb_pkg;

   localparam int MAX_DIM_DEF    = 4096;
   localparam int MAX_LEVELS_DEF = 12;
   localparam int CFG_W          = 13;
   localparam int DEPTH_W        = 32;
   localparam int LEVEL_W        = 4;
   localparam int TEXEL_W        = 11;
   localparam int CSR_IDX_W      = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0]     DIM_RESET        = 13'd1024;

   // command from controller to datapath
   typedef struct packed {
      logic start;     // latch a new pixel, begin at the image level
      logic advance;   // process the current level
      logic restart;   // clear position counters
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic emit;      // current level finished a texel
      logic more;      // a further level follows
      logic chain;     // the next level finishes a texel too
   } stat_type;

   // IEEE-754 strict less-than on raw bits; NaN never compares less
   function automatic logic fp_less(input logic [DEPTH_W-1:0] b,
                                    input logic [DEPTH_W-1:0] a);
      logic a_nan, b_nan, a_zero, b_zero;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      if (a_nan || b_nan)        fp_less = 1'b0;
      else if (a_zero && b_zero) fp_less = 1'b0;
      else if (b[31] != a[31])   fp_less = b[31];
      else if (!b[31])           fp_less = b[30:0] < a[30:0];
      else                       fp_less = b[30:0] > a[30:0];
   endfunction

endpackage

FILE: hdl/mdpb_ctrl.sv
// ----------------------------------------------------------------------------
// mdpb_ctrl
// Sequencer: walks one pixel up the levels, one level per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module mdpb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_busy,
   input  logic               cfg_write,
   input  mdpb_pkg::stat_type stat,
   output mdpb_pkg::cmd_type  cmd,
   output logic               emit_last
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;

   logic [1:0] state_ff, state_in;
   logic       step;

   // a level step may produce a result, so wait for a free output slot
   assign step      = (state_ff == ST_WALK) && !rsp_busy;
   assign req_ready = (state_ff == ST_IDLE) && !cfg_write;
   // last result of the pixel: top level, or the next level holds its texel open
   assign emit_last = step && stat.emit && (!stat.more || !stat.chain);

   always_comb begin
      cmd.start   = req_valid && req_ready;
      cmd.advance = step;
      cmd.restart = cfg_write;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (step && (!stat.emit || !stat.more)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

FILE: hdl/mdpb_datapath.sv
// ----------------------------------------------------------------------------
// mdpb_datapath
// Level counters, pair and row partial stores, float minimum, output register.
// ----------------------------------------------------------------------------
module mdpb_datapath #(
   parameter int MAX_DIM    = mdpb_pkg::MAX_DIM_DEF,
   parameter int MAX_LEVELS = mdpb_pkg::MAX_LEVELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mdpb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mdpb_pkg::CFG_W-1:0]          csr_write_data,
   input  logic [mdpb_pkg::DEPTH_W-1:0]        req_depth_bits,
   input  mdpb_pkg::cmd_type                   cmd,
   input  logic                                emit_last,
   output mdpb_pkg::stat_type                  stat,
   output logic                                rsp_busy,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mdpb_pkg::LEVEL_W-1:0]        rsp_mip_level,
   output logic [mdpb_pkg::TEXEL_W-1:0]        rsp_texel_x,
   output logic [mdpb_pkg::TEXEL_W-1:0]        rsp_texel_y,
   output logic [mdpb_pkg::DEPTH_W-1:0]        rsp_min_depth_bits,
   output logic                                rsp_last_of_item,
   output logic                                rsp_frame_done
);
   localparam int DW      = $clog2(MAX_DIM) + 1;
   localparam int LW      = $clog2(MAX_LEVELS + 1);
   localparam int IW      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int SD      = MAX_DIM + MAX_LEVELS;
   localparam int SW      = $clog2(SD + 1);
   localparam int DEPTH_W = mdpb_pkg::DEPTH_W;

   logic [mdpb_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [DW-1:0]  eff_w, eff_h, dim_max;
   logic [LW-1:0]  num_levels;
   logic [DW-1:0]  col_ff [MAX_LEVELS];
   logic [DW-1:0]  row_ff [MAX_LEVELS];
   logic [DEPTH_W-1:0] pair_ff [MAX_LEVELS];
   logic [DEPTH_W-1:0] row_mem [SD];
   logic [SW-1:0]  base_tab [MAX_LEVELS];
   logic [LW-1:0]  lvl_ff;
   logic [DEPTH_W-1:0] val_ff;
   logic [DEPTH_W-1:0] rd_ff;
   logic           rd_ok_ff;

   function automatic logic [DW-1:0] clamp(input logic [mdpb_pkg::CFG_W-1:0] v);
      if (v == '0) clamp = DW'(1);
      else if (32'(v) > MAX_DIM) clamp = DW'(MAX_DIM);
      else clamp = DW'(v);
   endfunction

   function automatic logic [DW-1:0] cshift(input logic [DW-1:0] v,
                                            input logic [LW-1:0] s);
      logic [DW:0] t;
      t = ({1'b0, v} + (({{DW{1'b0}}, 1'b1} << s) - 1'b1)) >> s;
      cshift = t[DW-1:0];
   endfunction

   // level number to store index; levels past the top fold onto level 0
   function automatic logic [IW-1:0] lvl_idx(input logic [LW-1:0] v);
      if (32'(v) < MAX_LEVELS) lvl_idx = IW'(v);
      else lvl_idx = '0;
   endfunction

   assign eff_w   = clamp(width_ff);
   assign eff_h   = clamp(height_ff);
   assign dim_max = (eff_w > eff_h) ? eff_w : eff_h;

   always_comb begin
      num_levels = '0;
      for (int i = 1; i <= MAX_LEVELS; i++)
         if (({{DW{1'b0}}, 1'b1} << (i - 1)) < dim_max) num_levels = LW'(i);
   end

   always_comb begin
      base_tab[0] = '0;
      for (int i = 1; i < MAX_LEVELS; i++)
         base_tab[i] = base_tab[i-1] + SW'((MAX_DIM + (1 << i) - 1) >> i);
   end

   // current level view
   logic [DW-1:0] x, y, pw, ph, cw, ch, nx, ny;
   logic [DW-1:0] cx, cy;
   logic [DW-1:0] x1, y1;
   logic [SW:0]   slot;
   logic          slot_ok;
   logic [DEPTH_W-1:0] acc, run;
   logic          lvl_act, done;

   assign lvl_act = lvl_ff < num_levels;
   assign x   = col_ff[lvl_idx(lvl_ff)];
   assign y   = row_ff[lvl_idx(lvl_ff)];
   assign pw  = cshift(eff_w, lvl_ff);
   assign ph  = cshift(eff_h, lvl_ff);
   assign cw  = cshift(eff_w, lvl_ff + 1'b1);
   assign ch  = cshift(eff_h, lvl_ff + 1'b1);
   assign cx  = x >> 1;
   assign cy  = y >> 1;
   assign slot    = (SW+1)'(base_tab[lvl_idx(lvl_ff)]) + (SW+1)'(cx);
   assign slot_ok = slot < (SW+1)'(SD);

   always_comb begin
      run = x[0] ? pair_ff[lvl_idx(lvl_ff)] : rd_ff;
      if (x[0] || (y[0] && rd_ok_ff))
         acc = mdpb_pkg::fp_less(val_ff, run) ? val_ff : run;
      else
         acc = val_ff;
      done = !((!x[0] && (x + 1'b1 < pw)) || (!y[0] && (y + 1'b1 < ph)));
      nx = x + 1'b1;
      ny = y;
      if (nx >= pw) begin
         nx = '0;
         ny = (y + 1'b1 >= ph) ? '0 : y + 1'b1;
      end
   end

   // position of the next level, whose sizes are cw by ch
   assign x1 = col_ff[lvl_idx(lvl_ff + 1'b1)];
   assign y1 = row_ff[lvl_idx(lvl_ff + 1'b1)];

   assign stat.emit  = lvl_act && done;
   assign stat.more  = (lvl_ff + 1'b1) < num_levels;
   assign stat.chain = !((!x1[0] && (x1 + 1'b1 < cw)) || (!y1[0] && (y1 + 1'b1 < ch)));

   // row store lookup, registered; address follows the level being entered
   logic [LW-1:0] rd_lvl;
   logic [SW:0]   rd_slot;
   assign rd_lvl  = cmd.start ? '0 : lvl_ff + 1'b1;
   assign rd_slot = (SW+1)'(base_tab[lvl_idx(rd_lvl)])
                  + (SW+1)'(col_ff[lvl_idx(rd_lvl)] >> 1);

   always_ff @(posedge clock) begin
      if (cmd.start || (cmd.advance && stat.emit)) begin
         rd_ok_ff <= rd_slot < (SW+1)'(SD);
         if (rd_slot < (SW+1)'(SD)) rd_ff <= row_mem[rd_slot[SW-1:0]];
      end
      if (cmd.advance && lvl_act && !(!x[0] && (x + 1'b1 < pw))
          && !y[0] && (y + 1'b1 < ph) && slot_ok)
         row_mem[slot[SW-1:0]] <= acc;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) val_ff <= req_depth_bits;
      else if (cmd.advance) val_ff <= acc;
      if (cmd.advance && lvl_act && !x[0] && (x + 1'b1 < pw))
         pair_ff[lvl_idx(lvl_ff)] <= acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mdpb_pkg::DIM_RESET;
         height_ff <= mdpb_pkg::DIM_RESET;
         lvl_ff    <= '0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else if (cmd.restart) begin
         unique case (csr_index)
            mdpb_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            mdpb_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else begin
         if (cmd.start) lvl_ff <= '0;
         else if (cmd.advance) lvl_ff <= lvl_ff + 1'b1;
         if (cmd.advance && lvl_act) begin
            col_ff[lvl_idx(lvl_ff)] <= nx;
            row_ff[lvl_idx(lvl_ff)] <= ny;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (cmd.advance && stat.emit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.advance && stat.emit) begin
         rsp_mip_level      <= mdpb_pkg::LEVEL_W'(lvl_ff + 1'b1);
         rsp_texel_x        <= mdpb_pkg::TEXEL_W'(cx);
         rsp_texel_y        <= mdpb_pkg::TEXEL_W'(cy);
         rsp_min_depth_bits <= acc;
         rsp_last_of_item   <= emit_last;
         rsp_frame_done     <= !stat.more && (cx + 1'b1 == cw) && (cy + 1'b1 == ch);
      end
   end

   assign rsp_busy = rsp_valid && !rsp_ready;
endmodule

FILE: hdl/min_depth_pyramid_builder.sv
// ----------------------------------------------------------------------------
// min_depth_pyramid_builder
// Hierarchical-Z min-depth pyramid from a raster stream of float depths.
// ----------------------------------------------------------------------------
// Usage: depth pixels enter on req_ (valid/ready) in raster order. Each pixel
// walks up the levels one level per clock in a small sequencer, while the
// output is not stalled; every level that finishes a texel puts one item on
// rsp_ (valid/ready), the last one of the pixel carrying last_of_item, the
// final texel of the top level carrying frame_done. After the accept, the
// walk visits each level that finishes a texel, and one more unless the top
// level did; each result is registered in the output register.
// A stalled receiver holds the output register; the walk waits on it and no
// new pixel is taken until the walk ends.
// Reset sets both sizes to 1024 and clears all position counters. A csr_
// write changes a size and restarts the frame; write only while idle.
// ----------------------------------------------------------------------------
module min_depth_pyramid_builder #(
   parameter int MAX_DIM    = mdpb_pkg::MAX_DIM_DEF,
   parameter int MAX_LEVELS = mdpb_pkg::MAX_LEVELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [mdpb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mdpb_pkg::CFG_W-1:0]       csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mdpb_pkg::DEPTH_W-1:0]     req_depth_bits,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mdpb_pkg::LEVEL_W-1:0]     rsp_mip_level,
   output logic [mdpb_pkg::TEXEL_W-1:0]     rsp_texel_x,
   output logic [mdpb_pkg::TEXEL_W-1:0]     rsp_texel_y,
   output logic [mdpb_pkg::DEPTH_W-1:0]     rsp_min_depth_bits,
   output logic                             rsp_last_of_item,
   output logic                             rsp_frame_done
);
   mdpb_pkg::cmd_type  cmd;
   mdpb_pkg::stat_type stat;
   logic rsp_busy, emit_last;

   mdpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_busy  (rsp_busy),
      .cfg_write (csr_write_enable),
      .stat      (stat),
      .cmd       (cmd),
      .emit_last (emit_last)
   );

   mdpb_datapath #(.MAX_DIM(MAX_DIM), .MAX_LEVELS(MAX_LEVELS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_depth_bits     (req_depth_bits),
      .cmd                (cmd),
      .emit_last          (emit_last),
      .stat               (stat),
      .rsp_busy           (rsp_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mip_level      (rsp_mip_level),
      .rsp_texel_x        (rsp_texel_x),
      .rsp_texel_y        (rsp_texel_y),
      .rsp_min_depth_bits (rsp_min_depth_bits),
      .rsp_last_of_item   (rsp_last_of_item),
      .rsp_frame_done     (rsp_frame_done)
   );

`ifndef SYNTHESIS
   a_no_accept_while_walking: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> !req_ready)
      else $error("input taken during level walk");
   a_frame_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_item)
      else $error("frame end not on last result of item");
   a_no_emit_over_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_busy |-> !cmd.advance)
      else $error("result overwrote stalled output");
`endif
endmodule

FILE: test/mdpb_checker.sv
// ----------------------------------------------------------------------------
// mdpb_checker
// Watches the pixel and texel channels of the pyramid builder, predicts every
// texel from the accepted pixels and compares each texel item field by field.
// ----------------------------------------------------------------------------
module mdpb_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [mdpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mdpb_pkg::CFG_W-1:0]     csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [mdpb_pkg::DEPTH_W-1:0]   req_depth_bits,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [mdpb_pkg::LEVEL_W-1:0]   rsp_mip_level,
   input  logic [mdpb_pkg::TEXEL_W-1:0]   rsp_texel_x,
   input  logic [mdpb_pkg::TEXEL_W-1:0]   rsp_texel_y,
   input  logic [mdpb_pkg::DEPTH_W-1:0]   rsp_min_depth_bits,
   input  logic                           rsp_last_of_item,
   input  logic                           rsp_frame_done,
   output int                             fail_count,
   output int                             pending_texels,
   output int                             texels_seen,
   output int                             frames_seen
);

   localparam int MAXD = mdpb_pkg::MAX_DIM_DEF;
   localparam int MAXL = mdpb_pkg::MAX_LEVELS_DEF;

   typedef struct {
      logic [mdpb_pkg::LEVEL_W-1:0] level;
      logic [mdpb_pkg::TEXEL_W-1:0] tx;
      logic [mdpb_pkg::TEXEL_W-1:0] ty;
      logic [mdpb_pkg::DEPTH_W-1:0] depth;
      logic                         last;
      logic                         done;
   } texel_type;

   texel_type   texel_queue[$];
   int          width_reg, height_reg, width_eff, height_eff, level_count;
   int          col_pos[MAXL+1], row_pos[MAXL+1];
   logic [31:0] pair_min[MAXL];
   logic [31:0] row_min[MAXL][MAXD];

   // strict float less-than on raw bits, written independently of the RTL
   function automatic bit depth_below(logic [31:0] b, logic [31:0] a);
      bit an, bn;
      an = (a[30:23] == 8'hFF) && (a[22:0] != 0);
      bn = (b[30:23] == 8'hFF) && (b[22:0] != 0);
      if (an || bn) return 0;
      if (a[30:0] == 0 && b[30:0] == 0) return 0;
      if (a[31] != b[31]) return b[31];
      return a[31] ? (b[30:0] > a[30:0]) : (b[30:0] < a[30:0]);
   endfunction

   function automatic int half_up(int v, int s);
      return (v + (1 << s) - 1) >> s;
   endfunction

   function automatic int clip_dim(int v);
      return v < 1 ? 1 : (v > MAXD ? MAXD : v);
   endfunction

   task automatic restart_pyramid();
      int m;
      width_eff = clip_dim(width_reg);
      height_eff = clip_dim(height_reg);
      m = width_eff > height_eff ? width_eff : height_eff;
      level_count = 0;
      while (level_count < MAXL && (1 << level_count) < m) level_count++;
      for (int i = 0; i <= MAXL; i++) begin
         col_pos[i] = 0;
         row_pos[i] = 0;
      end
   endtask

   task automatic predict_texels(logic [31:0] pixel);
      logic [31:0] v, acc;
      int          pw, ph, cw, ch, x, y, cx, cy, n;
      bit          finished;
      texel_type   t;
      v = pixel;
      n = 0;
      for (int l = 0; l < level_count; l++) begin
         pw = half_up(width_eff, l);
         ph = half_up(height_eff, l);
         cw = half_up(width_eff, l + 1);
         ch = half_up(height_eff, l + 1);
         x = col_pos[l];
         y = row_pos[l];
         cx = x >> 1;
         cy = y >> 1;
         finished = 0;
         if (x & 1) acc = depth_below(v, pair_min[l]) ? v : pair_min[l];
         else if (y & 1) acc = depth_below(v, row_min[l][cx]) ? v : row_min[l][cx];
         else acc = v;
         if (!(x & 1) && x + 1 < pw) pair_min[l] = acc;
         else if (!(y & 1) && y + 1 < ph) row_min[l][cx] = acc;
         else finished = 1;
         x++;
         if (x >= pw) begin
            x = 0;
            y++;
            if (y >= ph) y = 0;
         end
         col_pos[l] = x;
         row_pos[l] = y;
         if (!finished) break;
         t.level = mdpb_pkg::LEVEL_W'(l + 1);
         t.tx = mdpb_pkg::TEXEL_W'(cx);
         t.ty = mdpb_pkg::TEXEL_W'(cy);
         t.depth = acc;
         t.last = 1'b0;
         t.done = (l + 1 == level_count) && (cx + 1 == cw) && (cy + 1 == ch);
         texel_queue.push_back(t);
         n++;
         v = acc;
      end
      if (n > 0) texel_queue[texel_queue.size() - 1].last = 1'b1;
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      texel_type e;
      if (reset) begin
         width_reg = int'(mdpb_pkg::DIM_RESET);
         height_reg = int'(mdpb_pkg::DIM_RESET);
         restart_pyramid();
         texel_queue.delete();
         fail_count = 0;
         texels_seen = 0;
         frames_seen = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == mdpb_pkg::CSR_IMAGE_WIDTH) width_reg = int'(csr_write_data);
            else height_reg = int'(csr_write_data);
            restart_pyramid();
         end
         if (rsp_valid && rsp_ready) begin
            texels_seen++;
            if (texel_queue.size() == 0) begin
               report_mismatch("unexpected texel level", rsp_mip_level, 0);
            end else begin
               e = texel_queue.pop_front();
               if (rsp_mip_level !== e.level) report_mismatch("mip_level", rsp_mip_level, e.level);
               if (rsp_texel_x !== e.tx) report_mismatch("texel_x", rsp_texel_x, e.tx);
               if (rsp_texel_y !== e.ty) report_mismatch("texel_y", rsp_texel_y, e.ty);
               if (rsp_min_depth_bits !== e.depth)
                  report_mismatch("min_depth_bits", rsp_min_depth_bits, e.depth);
               if (rsp_last_of_item !== e.last)
                  report_mismatch("last_of_item", rsp_last_of_item, e.last);
               if (rsp_frame_done !== e.done)
                  report_mismatch("frame_done", rsp_frame_done, e.done);
               if (e.done) frames_seen++;
            end
         end
         if (req_valid && req_ready) predict_texels(req_depth_bits);
      end
      pending_texels = texel_queue.size();
   end

endmodule

FILE: test/tb_min_depth_pyramid_builder.sv
// ----------------------------------------------------------------------------
// tb_min_depth_pyramid_builder
// Streams depth frames of many sizes into the pyramid builder with bursty
// input and a stalling output; a checker beside the block predicts texels.
// ----------------------------------------------------------------------------
module tb_min_depth_pyramid_builder;

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           csr_write_enable = 0;
   logic [mdpb_pkg::CSR_IDX_W-1:0] csr_index = mdpb_pkg::CSR_IMAGE_WIDTH;
   logic [mdpb_pkg::CFG_W-1:0]     csr_write_data = 0;
   logic                           req_valid = 0;
   logic                           req_ready;
   logic [mdpb_pkg::DEPTH_W-1:0]   req_depth_bits = 0;
   logic                           rsp_valid;
   logic                           rsp_ready = 0;
   logic [mdpb_pkg::LEVEL_W-1:0]   rsp_mip_level;
   logic [mdpb_pkg::TEXEL_W-1:0]   rsp_texel_x, rsp_texel_y;
   logic [mdpb_pkg::DEPTH_W-1:0]   rsp_min_depth_bits;
   logic                           rsp_last_of_item, rsp_frame_done;
   int                             fail_count, pending_texels, texels_seen, frames_seen;
   int                             pixels_sent = 0;
   bit                             hold_off = 0;

   always #10 clock = ~clock;

   min_depth_pyramid_builder dut (.*);
   mdpb_checker u_checker (.*);

   // odd stall pattern, with quiet stretches and one long hold-off
   initial begin
      int k;
      k = 0;
      forever begin
         @(posedge clock);
         k++;
         if (hold_off) rsp_ready <= 0;
         else if ((k / 200) % 3 == 2) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   function automatic logic [31:0] pick_depth();
      case ($urandom_range(0, 9))
         0: return 32'h7FC0_0000 | $urandom_range(0, 255);   // NaN
         1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
         2: return $urandom_range(0, 1) ? 32'h7F80_0000 : 32'hFF80_0000;
         3: return $urandom();
         default: return {$urandom_range(0, 1) == 0 ? 1'b0 : 1'b1,
                          8'd120 + 8'($urandom_range(0, 15)), 23'($urandom())};
      endcase
   endfunction

   task automatic send_pixel(logic [31:0] d);
      req_valid <= 1;
      req_depth_bits <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic gap();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_texels != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_size(int w, int h);
      csr_write_enable <= 1;
      csr_index <= mdpb_pkg::CSR_IMAGE_WIDTH;
      csr_write_data <= mdpb_pkg::CFG_W'(w);
      @(posedge clock);
      csr_index <= mdpb_pkg::CSR_IMAGE_HEIGHT;
      csr_write_data <= mdpb_pkg::CFG_W'(h);
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   // random bursts over n pixels
   task automatic stream(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 12);
         if ($urandom_range(0, 3) == 0) burst = 40;
         for (int i = 0; i < burst && n > 0; i++, n--) send_pixel(pick_depth());
         if ($urandom_range(0, 2) != 0) gap();
      end
   endtask

   initial begin
      int w, h, n;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: 2x2 with extremes and zero ordering, then 3x3 odd edges
      set_size(2, 2);
      send_pixel(32'h0000_0000);
      send_pixel(32'h8000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h7FFF_FFFF);
      send_pixel(32'h7FC0_0000);
      send_pixel(32'h3F80_0000);
      send_pixel(32'hBF80_0000);
      send_pixel(32'h7F80_0000);
      drain();
      set_size(3, 3);
      stream(9);
      drain();
      // single pixel, zero sizes, oversize width (clamped, never completes)
      set_size(0, 1);
      stream(3);
      drain();
      set_size(8191, 1);
      stream(5);
      drain();

      // long receiver hold-off while the sender keeps offering
      set_size(4, 4);
      hold_off = 1;
      fork
         stream(16);
         repeat (150) @(posedge clock);
      join_any
      hold_off = 0;
      wait fork;
      drain();

      // random frames, mostly small; one frame at the largest width
      set_size(4096, 2);
      stream(40);
      drain();
      while (pixels_sent < 320) begin
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 9);
         if ($urandom_range(0, 5) == 0) w = $urandom_range(1, 40);
         set_size(w, h);
         n = w * h * $urandom_range(1, 2);
         if (n > 320 - pixels_sent) n = 320 - pixels_sent;
         stream(n);
         drain();
      end

      $display("Sent %0d pixels, checked %0d texels over %0d finished pyramids.",
               pixels_sent, texels_seen, frames_seen);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: min_depth_pyramid_builder.f
hdl/mdpb_pkg.sv
hdl/mdpb_ctrl.sv
hdl/mdpb_datapath.sv
hdl/min_depth_pyramid_builder.sv
test/mdpb_checker.sv
test/tb_min_depth_pyramid_builder.sv
